/* rtl/sxc_pkg.sv */
// sxc_pkg: shared constants, state encoding and controller/datapath structs
// for the stream XOR cipher with tag. No dependencies.
package sxc_pkg;

    // splitmix64 constants
    localparam logic [63:0] GOLDEN      = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_A       = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_B       = 64'h94D0_49BB_1331_11EB;

    // per-message seeds derived from the session key
    localparam logic [63:0] STREAM_SALT = 64'h5354_5245_414D_5F5F;
    localparam logic [63:0] TAG_SALT    = 64'h0054_4147_5F4B_4559;

    // hash is remixed when the low index bits are all ones
    localparam logic [5:0]  REMIX_MASK  = 6'h3F;

    // default message length limit
    localparam int          MAX_BYTES_DEF = 4096;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_KS,
        S_KS_WAIT,
        S_HASH,
        S_RMX,
        S_RMX_WAIT,
        S_TAG,
        S_TAG_WAIT,
        S_DONE
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic accept;     // latch input transaction, seed at message start
        logic ks_start;   // advance stream state, start keystream mix
        logic hash_step;  // encipher byte, fold into hash, bump index
        logic rmx_start;  // start hash remix
        logic rmx_take;   // write remix result back to hash
        logic tag_start;  // start tag mix
        logic out_load;   // load output register
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic mix_busy;
        logic mix_done;
        logic remix_due;
        logic last;
        logic out_free;
    } t_stat;

endpackage

/* rtl/sxc_mix.sv */
// sxc_mix: iterative splitmix64 finalizer on one shared 32x32 multiplier.
// Depends on sxc_pkg for the mix constants.
module sxc_mix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_x,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_result
);

    // partial product phases of one 64x64 low-half multiply
    localparam logic [1:0] PH_LL  = 2'd0;
    localparam logic [1:0] PH_LH  = 2'd1;
    localparam logic [1:0] PH_HL  = 2'd2;
    localparam logic [1:0] PH_SUM = 2'd3;

    logic        r_busy;
    logic        r_done;
    logic        r_pass;
    logic [1:0]  r_ph;
    logic [63:0] r_z;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_res;

    logic [63:0] mul_c;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] m_sum;

    // operand select for the shared multiplier
    always_comb begin
        mul_c = r_pass ? sxc_pkg::MIX_B : sxc_pkg::MIX_A;
        case (r_ph)
            PH_LL: begin
                mul_a = r_z[31:0];
                mul_b = mul_c[31:0];
            end
            PH_LH: begin
                mul_a = r_z[31:0];
                mul_b = mul_c[63:32];
            end
            default: begin
                mul_a = r_z[63:32];
                mul_b = mul_c[31:0];
            end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
        m_sum = r_acc + r_prod;
    end

    // sequencing: two multiply passes of four phases each
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pass <= 1'b0;
            r_ph   <= PH_LL;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_pass <= 1'b0;
                r_ph   <= PH_LL;
            end else if (r_busy) begin
                r_ph <= r_ph + 2'd1;
                if (r_ph == PH_SUM) begin
                    if (r_pass) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_pass <= 1'b1;
                    end
                end
            end
        end
    end

    // datapath: xor-shift, partial products, accumulate
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_z <= i_x ^ (i_x >> 30);
        end else if (r_busy) begin
            case (r_ph)
                PH_LL: begin
                    r_prod <= mul_p;
                end
                PH_LH: begin
                    r_acc  <= r_prod;
                    r_prod <= {mul_p[31:0], 32'd0};
                end
                PH_HL: begin
                    r_acc  <= m_sum;
                    r_prod <= {mul_p[31:0], 32'd0};
                end
                default: begin
                    if (!r_pass) begin
                        r_z <= m_sum ^ (m_sum >> 27);
                    end else begin
                        r_res <= m_sum ^ (m_sum >> 31);
                    end
                end
            endcase
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

/* rtl/sxc_dp.sv */
// sxc_dp: key, keystream and hash state, byte index, output register.
// Depends on sxc_pkg; instantiates sxc_mix.
module sxc_dp #(
    parameter int MAX_BYTES = sxc_pkg::MAX_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sxc_pkg::t_cmd i_cmd,
    output sxc_pkg::t_stat o_stat,
    input  logic          i_key_we,
    input  logic [63:0]   i_key_wdata,
    input  logic          i_command,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [7:0]    o_out_byte,
    output logic          o_tag_valid,
    output logic [63:0]   o_tag,
    output logic          o_over_length
);

    localparam int IDX_W = $clog2(MAX_BYTES + 1);

    logic [63:0]      r_key;
    logic             r_at_start;
    logic             r_ovf;
    logic [IDX_W-1:0] r_idx;
    logic [63:0]      r_stream;
    logic [63:0]      r_hash;
    logic             r_dec;
    logic [7:0]       r_data;
    logic             r_last;
    logic [7:0]       r_res_byte;
    logic             r_o_valid;
    logic [7:0]       r_o_byte;
    logic             r_o_tag_valid;
    logic [63:0]      r_o_tag;
    logic             r_o_ovf;

    logic [63:0] mix_base;
    logic [63:0] mix_x;
    logic        mix_start;
    logic        mix_busy;
    logic        mix_done;
    logic [63:0] mix_res;
    logic [7:0]  ks_byte;
    logic [7:0]  cipher;
    logic [63:0] hash_sum;
    logic [63:0] n_hash;
    logic        idx_full;
    logic        out_free;

    // mixer source: stream advance, remix, or tag over hash ^ length
    always_comb begin
        if (i_cmd.ks_start) begin
            mix_base = r_stream;
        end else if (i_cmd.rmx_start) begin
            mix_base = r_hash;
        end else begin
            mix_base = r_hash ^ 64'(r_idx);
        end
        mix_x     = mix_base + sxc_pkg::GOLDEN;
        mix_start = i_cmd.ks_start | i_cmd.rmx_start | i_cmd.tag_start;
    end

    sxc_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mix_start),
        .i_x      (mix_x),
        .o_busy   (mix_busy),
        .o_done   (mix_done),
        .o_result (mix_res)
    );

    // encipher and hash fold
    always_comb begin
        ks_byte  = r_data ^ mix_res[7:0];
        cipher   = r_dec ? r_data : ks_byte;
        hash_sum = {56'd0, cipher} + sxc_pkg::GOLDEN + (r_hash << 6) + (r_hash >> 2)
                 + 64'(r_idx);
        n_hash   = r_hash ^ hash_sum;
        idx_full = (r_idx >= IDX_W'(MAX_BYTES));
        out_free = !r_o_valid || i_out_ready;
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= 64'd0;
            r_at_start <= 1'b1;
            r_ovf      <= 1'b0;
            r_idx      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_key_we) begin
                r_key <= i_key_wdata;
            end
            if (i_cmd.accept && r_at_start) begin
                r_at_start <= 1'b0;
                r_ovf      <= 1'b0;
                r_idx      <= '0;
            end
            if (i_cmd.hash_step) begin
                if (idx_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_at_start <= r_last;
                r_o_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_dec  <= i_command;
            r_data <= i_data_byte;
            r_last <= i_last;
            if (r_at_start) begin
                r_stream <= r_key ^ sxc_pkg::STREAM_SALT;
                r_hash   <= r_key ^ sxc_pkg::TAG_SALT;
            end
        end
        if (i_cmd.ks_start) begin
            r_stream <= mix_x;
        end
        if (i_cmd.hash_step) begin
            r_hash     <= n_hash;
            r_res_byte <= ks_byte;
        end
        if (i_cmd.rmx_take) begin
            r_hash <= mix_res;
        end
        if (i_cmd.out_load) begin
            r_o_byte      <= r_res_byte;
            r_o_tag_valid <= r_last;
            r_o_tag       <= r_last ? mix_res : 64'd0;
            r_o_ovf       <= r_ovf;
        end
    end

    always_comb begin
        o_stat.mix_busy  = mix_busy;
        o_stat.mix_done  = mix_done;
        o_stat.remix_due = (r_idx[5:0] == sxc_pkg::REMIX_MASK);
        o_stat.last      = r_last;
        o_stat.out_free  = out_free;
    end

    assign o_out_valid   = r_o_valid;
    assign o_out_byte    = r_o_byte;
    assign o_tag_valid   = r_o_tag_valid;
    assign o_tag         = r_o_tag;
    assign o_over_length = r_o_ovf;

endmodule

/* rtl/sxc_ctrl.sv */
// sxc_ctrl: per-byte sequencer: keystream mix, hash fold, remix, tag, output.
// Depends on sxc_pkg for the state type and command/status structs.
module sxc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sxc_pkg::t_stat i_stat,
    output sxc_pkg::t_cmd  o_cmd
);

    sxc_pkg::t_state r_state;
    sxc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sxc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sxc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = sxc_pkg::S_KS;
                end
            end
            sxc_pkg::S_KS: begin
                o_cmd.ks_start = 1'b1;
                n_state        = sxc_pkg::S_KS_WAIT;
            end
            sxc_pkg::S_KS_WAIT: begin
                if (i_stat.mix_done) begin
                    n_state = sxc_pkg::S_HASH;
                end
            end
            sxc_pkg::S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.remix_due) begin
                    n_state = sxc_pkg::S_RMX;
                end else if (i_stat.last) begin
                    n_state = sxc_pkg::S_TAG;
                end else begin
                    n_state = sxc_pkg::S_DONE;
                end
            end
            sxc_pkg::S_RMX: begin
                o_cmd.rmx_start = 1'b1;
                n_state         = sxc_pkg::S_RMX_WAIT;
            end
            sxc_pkg::S_RMX_WAIT: begin
                if (i_stat.mix_done) begin
                    o_cmd.rmx_take = 1'b1;
                    n_state        = i_stat.last ? sxc_pkg::S_TAG : sxc_pkg::S_DONE;
                end
            end
            sxc_pkg::S_TAG: begin
                o_cmd.tag_start = 1'b1;
                n_state         = sxc_pkg::S_TAG_WAIT;
            end
            sxc_pkg::S_TAG_WAIT: begin
                if (i_stat.mix_done) begin
                    n_state = sxc_pkg::S_DONE;
                end
            end
            sxc_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = sxc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sxc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/stream_xor_cipher_with_tag.sv */
// stream_xor_cipher_with_tag: top level joining sequencer and datapath.
// Depends on sxc_pkg, sxc_ctrl, sxc_dp (which holds sxc_mix).
//
// Byte-serial stream cipher with a keyed 64-bit tag. Each input transaction
// carries one byte, a mode (0 encrypt, 1 decrypt) and a last mark; each
// produces exactly one output transaction with the enciphered byte, the
// tag (nonzero-meaningful only with tag_valid on the last byte) and a sticky
// over-length flag. The session key is sampled at the first byte of each
// message. Bytes are handled one at a time: each byte goes through the keystream
// mix, the hash fold and, once the output register is free, the output load
// before the next byte is accepted; every 64th byte adds the hash remix and
// the last byte adds the tag mix. The single splitmix64 unit builds each 64-bit
// multiply from three 32x32 partial products on one shared multiplier.
// A finished result waits in the output register while the next byte is accepted.
module stream_xor_cipher_with_tag #(
    parameter int MAX_BYTES = sxc_pkg::MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_key_we,
    input  logic [63:0] i_key_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_tag_valid,
    output logic [63:0] o_tag,
    output logic        o_over_length
);

    sxc_pkg::t_cmd  cmd;
    sxc_pkg::t_stat stat;

    sxc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sxc_dp #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_key_we      (i_key_we),
        .i_key_wdata   (i_key_wdata),
        .i_command     (i_command),
        .i_data_byte   (i_data_byte),
        .i_last        (i_last),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_tag_valid   (o_tag_valid),
        .o_tag         (o_tag),
        .o_over_length (o_over_length)
    );

    // output register is only loaded when its transaction has gone out
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten before transaction completed");

    // mixer is never restarted while it is working
    a_mix_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.ks_start || cmd.rmx_start || cmd.tag_start) |-> !stat.mix_busy)
        else $error("mixer started while busy");

    // at most one mixer job is requested at a time
    a_mix_one_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.ks_start, cmd.rmx_start, cmd.tag_start}))
        else $error("several mixer sources requested");

    // tag reads zero on every byte that is not the last
    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tag_valid) |-> (o_tag == 64'd0))
        else $error("nonzero tag without tag_valid");

endmodule
